/* design/pch_pkg.sv */
// ----------------------------------------------------------------------------
// pch_pkg
// Shared constants, codes and types for the printable character histogram.
// ----------------------------------------------------------------------------
package pch_pkg;

  localparam int NUM_BINS   = 95;
  localparam int COUNT_BITS = 32;
  localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RESULT_W   = 32;

  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_END   = 2'd1,
    FUNC_ABORT = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MERGE,
    ST_DRAIN
  } state_t;

  // item held while its memory read completes
  typedef struct packed {
    func_t            func;
    logic             printable;
    logic             hit;
    logic [BIN_W-1:0] bin;
    logic             last;
  } stage_t;

endpackage

/* design/pch_if.sv */
// ----------------------------------------------------------------------------
// pch_req_if / pch_rsp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface pch_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic [6:0] bin_index;

  modport source (output valid, func, data_byte, end_of_message, bin_index, input ready);
  modport sink   (input valid, func, data_byte, end_of_message, bin_index, output ready);
endinterface

interface pch_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] result_value;

  modport source (output valid, result_kind, result_value, input ready);
  modport sink   (input valid, result_kind, result_value, output ready);
endinterface

/* design/pch_ram.sv */
// ----------------------------------------------------------------------------
// pch_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pch_ram #(
  parameter int DEPTH = 95,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/printable_char_histogram.sv */
// ----------------------------------------------------------------------------
// printable_char_histogram
// Per-message histogram of printable bytes, merged into running bin totals
// at message end; bin totals readable one at a time.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  req     | in  | func, data_byte, end_of_message, bin_index
//  rsp     | out | result_kind, result_value
//
//  Data bytes, aborts and bin reads: one word per cycle; staged bin updated
//  by read-modify-write with forwarding from the previous write.
//  Message end: req held off while the merge engine walks both bin
//  memories (one bin per cycle).
//  Reset: per-entry valid bits make all bins read as zero; no clearing pass.
//  A result waiting on rsp stalls the read stage, and with it req.
// ----------------------------------------------------------------------------
module printable_char_histogram (
  input  logic      clk,
  input  logic      rst,
  pch_req_if.sink   req,
  pch_rsp_if.source rsp
);

  localparam int BW = pch_pkg::BIN_W;
  localparam int CW = pch_pkg::COUNT_BITS;
  localparam int NB = pch_pkg::NUM_BINS;

  pch_pkg::state_t state, state_next;
  logic run, merge_rd, drain;

  logic [BW-1:0] ptr;
  logic          m_wv;
  logic [BW-1:0] m_wa;

  pch_pkg::stage_t p1;
  logic            p1_valid;
  logic            p1_res, p1_end, p1_stall, p1_fire;

  logic          accept;
  logic [7:0]    byte_off;
  logic [7:0]    idx8;
  logic          byte_printable;

  logic [NB-1:0] stg_vld;
  logic [NB-1:0] tot_vld;

  logic          stg_re, tot_re, stg_we, tot_we;
  logic [BW-1:0] stg_raddr, tot_raddr;
  logic [CW-1:0] stg_rdata, tot_rdata;
  logic [CW-1:0] stg_old, stg_new, tot_wdata;
  logic [CW-1:0] tot_val, stg_cur, tot_cur;

  logic          lw_valid;
  logic [BW-1:0] lw_addr;
  logic [CW-1:0] lw_data;

  logic [CW-1:0] msg_count, cnt_new;

  logic                         out_valid;
  logic                         out_kind;
  logic [pch_pkg::RESULT_W-1:0] out_value;

  // FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pch_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pch_pkg::ST_RUN:   if (p1_fire && p1_end) state_next = pch_pkg::ST_MERGE;
      pch_pkg::ST_MERGE: if (ptr == BW'(NB - 1)) state_next = pch_pkg::ST_DRAIN;
      pch_pkg::ST_DRAIN: state_next = pch_pkg::ST_RUN;
      default:           state_next = pch_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    run      = 1'b0;
    merge_rd = 1'b0;
    drain    = 1'b0;
    case (state)
      pch_pkg::ST_RUN:   run      = 1'b1;
      pch_pkg::ST_MERGE: merge_rd = 1'b1;
      pch_pkg::ST_DRAIN: drain    = 1'b1;
      default:           run      = 1'b0;
    endcase
  end

  // merge sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      m_wv <= 1'b0;
    end else begin
      m_wv <= merge_rd;
      if (merge_rd) begin
        ptr <= ptr + 1'b1;
      end else begin
        ptr <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_wa <= ptr;
  end

  // request decode
  assign accept         = req.valid && req.ready;
  assign byte_off       = req.data_byte - pch_pkg::FIRST_PRINTABLE;
  assign idx8           = {1'b0, req.bin_index};
  assign byte_printable = req.data_byte inside
                          {[pch_pkg::FIRST_PRINTABLE : pch_pkg::LAST_PRINTABLE]};

  assign p1_res   = p1_valid && ((p1.func inside {pch_pkg::FUNC_READ, pch_pkg::FUNC_END}) ||
                                 (p1.func == pch_pkg::FUNC_DATA && p1.last));
  assign p1_end   = p1_valid && ((p1.func == pch_pkg::FUNC_END) ||
                                 (p1.func == pch_pkg::FUNC_DATA && p1.last));
  assign p1_stall = p1_res && out_valid && !rsp.ready;
  assign p1_fire  = p1_valid && !p1_stall;

  assign req.ready = run && !p1_stall && !p1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (!p1_stall) begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1.func      <= pch_pkg::func_t'(req.func);
      p1.printable <= byte_printable;
      p1.last      <= req.end_of_message;
      if (pch_pkg::func_t'(req.func) == pch_pkg::FUNC_READ) begin
        p1.hit <= {1'b0, idx8} < 9'(NB);
        p1.bin <= idx8[BW-1:0];
      end else begin
        p1.hit <= byte_printable && ({1'b0, byte_off} < 9'(NB));
        p1.bin <= byte_off[BW-1:0];
      end
    end
  end

  // memories
  assign stg_re    = merge_rd || accept;
  assign stg_raddr = merge_rd ? ptr : byte_off[BW-1:0];
  assign tot_re    = merge_rd || (accept && pch_pkg::func_t'(req.func) == pch_pkg::FUNC_READ);
  assign tot_raddr = merge_rd ? ptr : idx8[BW-1:0];

  pch_ram #(.DEPTH(NB), .WIDTH(CW), .AW(BW)) u_staged (
    .clk   (clk),
    .we    (stg_we),
    .waddr (p1.bin),
    .wdata (stg_new),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  pch_ram #(.DEPTH(NB), .WIDTH(CW), .AW(BW)) u_total (
    .clk   (clk),
    .we    (tot_we),
    .waddr (m_wa),
    .wdata (tot_wdata),
    .re    (tot_re),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  // staged bin read-modify-write
  assign stg_old = (lw_valid && lw_addr == p1.bin) ? lw_data :
                   (stg_vld[p1.bin] ? stg_rdata : '0);
  assign stg_new = stg_old + 1'b1;
  assign stg_we  = p1_fire && p1.func == pch_pkg::FUNC_DATA && p1.printable && p1.hit;
  assign cnt_new = msg_count + CW'(p1.func == pch_pkg::FUNC_DATA && p1.printable);

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (!p1_stall) begin
      lw_valid <= stg_we;
    end
  end

  always_ff @(posedge clk) begin
    if (!p1_stall) begin
      lw_addr <= p1.bin;
      lw_data <= stg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_count <= '0;
    end else if (p1_fire) begin
      case (p1.func)
        pch_pkg::FUNC_DATA:  msg_count <= p1.last ? '0 : cnt_new;
        pch_pkg::FUNC_END:   msg_count <= '0;
        pch_pkg::FUNC_ABORT: msg_count <= '0;
        default:             msg_count <= msg_count;
      endcase
    end
  end

  // merge write
  assign stg_cur   = stg_vld[m_wa] ? stg_rdata : '0;
  assign tot_cur   = tot_vld[m_wa] ? tot_rdata : '0;
  assign tot_wdata = tot_cur + stg_cur;
  assign tot_we    = m_wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= '0;
    end else if (drain || (p1_fire && p1.func == pch_pkg::FUNC_ABORT)) begin
      stg_vld <= '0;
    end else if (stg_we) begin
      stg_vld[p1.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_vld <= '0;
    end else if (tot_we) begin
      tot_vld[m_wa] <= 1'b1;
    end
  end

  // result register
  assign tot_val = (p1.hit && tot_vld[p1.bin]) ? tot_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_fire && p1_res) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_fire && p1_res) begin
      if (p1.func == pch_pkg::FUNC_READ) begin
        out_kind  <= pch_pkg::KIND_TOTAL;
        out_value <= pch_pkg::RESULT_W'(tot_val);
      end else begin
        out_kind  <= pch_pkg::KIND_COUNT;
        out_value <= pch_pkg::RESULT_W'(cnt_new);
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_kind  = out_kind;
  assign rsp.result_value = out_value;

`ifndef SYNTHESIS
  a_merge_entry: assert property (@(posedge clk) disable iff (rst)
    (state == pch_pkg::ST_RUN && !(p1_fire && p1_end)) |=> state == pch_pkg::ST_RUN)
    else $error("merge started without a message end");

  a_no_stage_in_merge: assert property (@(posedge clk) disable iff (rst)
    (state != pch_pkg::ST_RUN) |-> !p1_valid)
    else $error("request in flight during merge");

  a_total_write_merge: assert property (@(posedge clk) disable iff (rst)
    m_wv |-> (state == pch_pkg::ST_MERGE || state == pch_pkg::ST_DRAIN))
    else $error("total bin written outside merge");

  a_stage_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == pch_pkg::ST_DRAIN) |=> (stg_vld == '0 && !lw_valid && msg_count == '0))
    else $error("staged bins not cleared after merge");
`endif

endmodule
